### sv/rgbcf_pkg.sv
// Shared constants, codes and types of the RGB convolution filter.
// Depends on nothing; every other file but rgbcf_ram imports it.
package rgbcf_pkg;
  localparam int MAX_RADIUS = 2;
  localparam int MAX_WIDTH  = 1024;
  localparam int SIDE_MAX   = 2 * MAX_RADIUS + 1;
  localparam int KERN_DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int LINE_DEPTH = SIDE_MAX * MAX_WIDTH;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(SIDE_MAX);
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int KIDX_W     = $clog2(KERN_DEPTH);
  localparam int ACC_W      = 30;
  localparam int Q_DEPTH    = 8;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_PIXEL = 2'd1;
  localparam logic [1:0] FN_FLUSH = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [1:0] K_LOAD  = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_JOB   = 2'd2;

  typedef struct packed {
    logic [10:0] wid;
    logic [15:0] hgt;
    logic [1:0]  rad;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       pix;
    logic [KIDX_W-1:0] kidx;
    logic [15:0]       kval;
    logic [COL_W-1:0]  col;
    logic [15:0]       row;
    logic [SLOT_W-1:0] slot;
    logic              lir;
    logic              lof;
  } entry_t;
endpackage

### sv/rgbcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rgbcf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/rgbcf_queue.sv
// Short command queue between front and back of the filter.
// Depends on rgbcf_pkg.
module rgbcf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rgbcf_pkg::entry_t     push_data,
  input  logic                  pop,
  output rgbcf_pkg::entry_t     head,
  output logic                  full,
  output logic                  empty
);
  import rgbcf_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  entry_t          store [Q_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;

  assign full  = (count == (PW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = store[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

### sv/rgbcf_front.sv
// Front end: configuration, input transfers, position tracking and job issue.
// Depends on rgbcf_pkg.
module rgbcf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [15:0]       cfg_data,
  input  logic              full,
  output logic              push,
  output rgbcf_pkg::entry_t push_data,
  output rgbcf_pkg::cfg_t   cfg
);
  import rgbcf_pkg::*;

  logic [10:0]       raw_wid;
  logic [15:0]       raw_hgt;
  logic [1:0]        raw_rad;
  logic [COL_W-1:0]  col;
  logic [16:0]       row;
  logic [SLOT_W-1:0] rslot;
  logic              busy;
  logic [COL_W-1:0]  jcol;
  logic [COL_W-1:0]  jend;
  logic [15:0]       jrow;
  logic [SLOT_W-1:0] jslot;

  logic              accept;
  logic              is_pos;
  logic [KIDX_W-1:0] in_idx;
  logic              row_ok;
  logic              col_last;
  logic              col_ge;
  logic              has_jobs;
  logic [COL_W-1:0]  first;
  logic [COL_W-1:0]  last_col;
  logic [15:0]       orow;
  logic [3:0]        slot_sum;
  logic [SLOT_W-1:0] slot0;
  logic [16:0]       row_inc;

  always_comb begin
    cfg.wid = (raw_wid == '0) ? 11'd1 :
              (raw_wid > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : raw_wid;
    cfg.hgt = (raw_hgt == '0) ? 16'd1 : raw_hgt;
    cfg.rad = (raw_rad > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : raw_rad;
  end

  assign s_tready = !busy && !full;
  assign accept   = s_tvalid && s_tready;
  assign is_pos   = (s_tuser == FN_PIXEL) || (s_tuser == FN_FLUSH);
  assign in_idx   = s_tdata[4:0];

  assign last_col = COL_W'(cfg.wid - 11'd1);
  assign row_ok   = row >= {15'b0, cfg.rad};
  assign col_last = col == last_col;
  assign col_ge   = col >= COL_W'(cfg.rad);
  assign has_jobs = row_ok && (col_last || col_ge);
  assign first    = col_ge ? col - COL_W'(cfg.rad) : '0;
  assign orow     = 16'(row - {15'b0, cfg.rad});
  assign slot_sum = {1'b0, rslot} + 4'(SIDE_MAX) - {1'b0, cfg.rad, 1'b0};
  assign slot0    = (slot_sum >= 4'(SIDE_MAX)) ? SLOT_W'(slot_sum - 4'(SIDE_MAX))
                                               : SLOT_W'(slot_sum);
  assign row_inc  = row + 17'd1;

  always_comb begin
    push_data      = '0;
    push           = 1'b0;
    if (busy) begin
      push           = !full;
      push_data.kind = K_JOB;
      push_data.col  = jcol;
      push_data.row  = jrow;
      push_data.slot = jslot;
      push_data.lir  = (jcol == jend);
      push_data.lof  = (jcol == last_col) && (jrow == cfg.hgt - 16'd1);
    end else if (accept && s_tuser == FN_LOAD) begin
      push           = in_idx < KIDX_W'(KERN_DEPTH);
      push_data.kind = K_LOAD;
      push_data.kidx = in_idx;
      push_data.kval = s_tdata[20:5];
    end else if (accept && is_pos) begin
      push           = 1'b1;
      push_data.kind = K_WRITE;
      push_data.addr = {rslot, col};
      push_data.pix  = (s_tuser == FN_PIXEL) ?
                       {s_tdata[28:21], s_tdata[36:29], s_tdata[44:37]} : 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_wid <= 11'(MAX_WIDTH);
      raw_hgt <= 16'd1;
      raw_rad <= 2'd1;
      col     <= '0;
      row     <= '0;
      rslot   <= '0;
      busy    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_WIDTH:  raw_wid <= cfg_data[10:0];
          REG_HEIGHT: raw_hgt <= cfg_data;
          REG_RADIUS: raw_rad <= cfg_data[1:0];
          default: ;
        endcase
        if (cfg_addr inside {REG_WIDTH, REG_HEIGHT, REG_RADIUS}) begin
          col   <= '0;
          row   <= '0;
          rslot <= '0;
        end
      end
      if (accept && is_pos) begin
        busy  <= has_jobs;
        jcol  <= first;
        jend  <= col_last ? last_col : first;
        jrow  <= orow;
        jslot <= slot0;
        if (!col_last) begin
          col <= col + 1'b1;
        end else begin
          col <= '0;
          if (row_inc >= {1'b0, cfg.hgt} + {15'b0, cfg.rad}) begin
            row   <= '0;
            rslot <= '0;
          end else begin
            row   <= row_inc;
            rslot <= (rslot == SLOT_W'(SIDE_MAX - 1)) ? '0 : rslot + 1'b1;
          end
        end
      end
      if (busy && !full) begin
        jcol <= jcol + 1'b1;
        if (jcol == jend) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

### sv/rgbcf_back.sv
// Back end: kernel store, line store writes and the tap-serial MAC per job.
// Depends on rgbcf_pkg and rgbcf_ram.
module rgbcf_back (
  input  logic              clk,
  input  logic              rst,
  input  rgbcf_pkg::cfg_t   cfg,
  input  rgbcf_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);
  import rgbcf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TAP  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        st;
  logic              wcnt;
  logic [15:0]       kern [KERN_DEPTH];
  logic [COL_W-1:0]  ocol;
  logic [15:0]       orow;
  logic [SLOT_W-1:0] slot;
  logic              lir;
  logic              lof;
  logic [2:0]        dy;
  logic [2:0]        dx;
  logic [KIDX_W-1:0] kidx;
  logic              s1_v;
  logic [15:0]       s1_coef;
  logic              s2_v;
  logic [24:0]       p_r;
  logic [24:0]       p_g;
  logic [24:0]       p_b;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_g;
  logic [ACC_W-1:0]  acc_b;

  logic              ram_we;
  logic [23:0]       rdata;
  logic [2:0]        side_m1;
  logic [17:0]       yy;
  logic [11:0]       xx;
  logic              inb;
  logic              tap_end;
  logic              out_free;

  assign side_m1  = {cfg.rad, 1'b0};
  assign yy       = {2'b0, orow} + {15'b0, dy} - {16'b0, cfg.rad};
  assign xx       = {2'b0, ocol} + {9'b0, dx} - {10'b0, cfg.rad};
  assign inb      = !yy[17] && (yy[16:0] < {1'b0, cfg.hgt}) &&
                    !xx[11] && (xx[10:0] < cfg.wid);
  assign tap_end  = (dx == side_m1) && (dy == side_m1);
  assign out_free = !m_tvalid || m_tready;
  assign pop      = (st == ST_IDLE) && !empty;
  assign ram_we   = pop && (head.kind == K_WRITE);

  rgbcf_ram #(.W(24), .D(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.addr),
    .wdata (head.pix),
    .raddr ({slot, xx[COL_W-1:0]}),
    .rdata (rdata)
  );

  function automatic logic [7:0] chan(input logic [ACC_W-1:0] a);
    logic [7:0] q;
    q = a[19:12];
    if (a[ACC_W-1] && (a[11:0] != '0)) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (pop && head.kind == K_LOAD) begin
      kern[head.kidx] <= head.kval;
    end
    s1_coef <= kern[kidx];
    p_r <= $signed(s1_coef) * $signed({1'b0, rdata[23:16]});
    p_g <= $signed(s1_coef) * $signed({1'b0, rdata[15:8]});
    p_b <= $signed(s1_coef) * $signed({1'b0, rdata[7:0]});
    if (pop) begin
      ocol  <= head.col;
      orow  <= head.row;
      slot  <= head.slot;
      lir   <= head.lir;
      lof   <= head.lof;
      dy    <= '0;
      dx    <= '0;
      kidx  <= '0;
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else begin
      if (st == ST_TAP) begin
        kidx <= kidx + 1'b1;
        if (dx == side_m1) begin
          dx   <= '0;
          dy   <= dy + 1'b1;
          slot <= (slot == SLOT_W'(SIDE_MAX - 1)) ? '0 : slot + 1'b1;
        end else begin
          dx <= dx + 1'b1;
        end
      end
      if (s2_v) begin
        acc_r <= acc_r + {{(ACC_W-25){p_r[24]}}, p_r};
        acc_g <= acc_g + {{(ACC_W-25){p_g[24]}}, p_g};
        acc_b <= acc_b + {{(ACC_W-25){p_b[24]}}, p_b};
      end
    end
    if (st == ST_FIN && out_free) begin
      m_tdata <= {6'b0, orow, ocol, chan(acc_b), chan(acc_g), chan(acc_r)};
      m_tlast <= lir;
      m_tuser <= lof;
    end
    if (rst) begin
      st       <= ST_IDLE;
      wcnt     <= 1'b0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      s1_v <= (st == ST_TAP) && inb;
      s2_v <= s1_v;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (pop && head.kind == K_JOB) begin
            st <= ST_TAP;
          end
        end
        ST_TAP: begin
          if (tap_end) begin
            st   <= ST_WAIT;
            wcnt <= 1'b1;
          end
        end
        ST_WAIT: begin
          if (wcnt) begin
            wcnt <= 1'b0;
          end else begin
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            st       <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end
endmodule

### sv/rgb_2d_convolution_filter.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata coef/pixel, tuser func
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata pixel+position, tlast, tuser
// cfg       in   cfg_we                         cfg_addr, cfg_data
// A job (one output pixel) runs its (2R+1)^2 taps in turn on the shared three-channel MAC,
// then waits for the multiply pipeline to drain before the result is handed off.
// The back end applies loads and line store writes as it pops them from the queue.
// rst is synchronous; the front stalls s_axis when the queue is full or jobs remain.
// Top level of the RGB convolution filter; depends on rgbcf_pkg and all rgbcf_ modules.
module rgb_2d_convolution_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // coef_index, coef_value, pixel_red, pixel_green, pixel_blue
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_red, out_green, out_blue, out_column, out_row
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,  // last_of_frame
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import rgbcf_pkg::*;

  cfg_t   cfg;
  entry_t push_data;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  rgbcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .full      (q_full),
    .push      (push),
    .push_data (push_data),
    .cfg       (cfg)
  );

  rgbcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  rgbcf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tlast  (m_axis_tlast),
    .m_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("queue pop while empty");
  a_ready_room: assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> !q_full)
    else $error("input ready with full queue");
  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif
endmodule

### tb/tb_top.sv
// Self-checking bench for the RGB convolution filter: drives coefficient loads,
// pixels and flush positions, predicts every filtered pixel and checks it.
// Depends on rgbcf_pkg and the rgb_2d_convolution_filter RTL.
module tb_top;
  import rgbcf_pkg::*;

  localparam int  CLIP_LIMIT   = 1000000;
  localparam int  DRAIN_CYCLES = 150;
  localparam logic [1:0] FN_NONE = 2'd3;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [9:0]  col;
    logic [15:0] row;
    logic        lir;
    logic        lof;
  } pix_out_t;

  typedef struct {
    logic [1:0]  func;
    logic [4:0]  idx;
    logic [15:0] coef;
    logic [7:0]  r, g, b;
    bit          chk;
    logic [7:0]  er, eg, eb;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // coef_index, coef_value, pixel_red, pixel_green, pixel_blue
  logic [1:0]  s_axis_tuser = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // out_red, out_green, out_blue, out_column, out_row
  logic        m_axis_tlast;
  logic        m_axis_tuser;       // last_of_frame
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  rgb_2d_convolution_filter dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter state as predicted
  logic [10:0] img_w;
  logic [15:0] img_h;
  logic [1:0]  rad_reg;
  logic [15:0] kern [KERN_DEPTH];
  logic [23:0] lines [LINE_DEPTH];
  int          pos_col, pos_row;

  pix_out_t    pending_pix[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          idle_on = 1'b0;
  int          stall_left = 0;
  int          items_sent = 0;

  function automatic int eff_w();
    return (img_w == 0) ? 1 : (img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
  endfunction

  function automatic int eff_h();
    return (img_h == 0) ? 1 : int'(img_h);
  endfunction

  function automatic int eff_r();
    return (rad_reg > MAX_RADIUS) ? MAX_RADIUS : int'(rad_reg);
  endfunction

  function automatic logic [7:0] chan_of(longint acc);
    longint q;
    q = acc / 4096;
    return q[7:0];
  endfunction

  function automatic pix_out_t conv_at(int ocol, int orow);
    pix_out_t    o;
    longint      ar, ag, ab, k;
    int          rad, side, yy, xx, slot;
    logic [23:0] p;
    ar = 0; ag = 0; ab = 0;
    rad = eff_r();
    side = 2 * rad + 1;
    for (int dy = 0; dy < side; dy++) begin
      yy = orow - rad + dy;
      if (yy < 0 || yy >= eff_h()) continue;
      slot = yy % SIDE_MAX;
      for (int dx = 0; dx < side; dx++) begin
        xx = ocol - rad + dx;
        if (xx < 0 || xx >= eff_w()) continue;
        p = lines[slot * MAX_WIDTH + xx];
        k = longint'($signed(kern[dy * side + dx]));
        ar += longint'(p[23:16]) * k;
        ag += longint'(p[15:8]) * k;
        ab += longint'(p[7:0]) * k;
      end
    end
    o.red = chan_of(ar);
    o.green = chan_of(ag);
    o.blue = chan_of(ab);
    o.col = ocol[9:0];
    o.row = orow[15:0];
    o.lir = 1'b0;
    o.lof = (ocol + 1 == eff_w() && orow + 1 == eff_h());
    return o;
  endfunction

  function automatic void filter_accept(logic [1:0] f, logic [4:0] ix, logic [15:0] v,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int wid, rad, n, first;
    if (f == FN_LOAD) begin
      if (ix < KERN_DEPTH) kern[ix] = v;
      return;
    end
    if (f == FN_NONE) return;
    wid = eff_w();
    rad = eff_r();
    n = 0;
    lines[(pos_row % SIDE_MAX) * MAX_WIDTH + pos_col] = (f == FN_PIXEL) ? {r, g, b} : 24'd0;
    if (pos_row >= rad) begin
      if (pos_col + 1 == wid) begin
        first = (pos_col >= rad) ? pos_col - rad : 0;
        for (int c = first; c < wid; c++) begin
          pending_pix.push_back(conv_at(c, pos_row - rad));
          n++;
        end
      end else if (pos_col >= rad) begin
        pending_pix.push_back(conv_at(pos_col - rad, pos_row - rad));
        n++;
      end
      if (n > 0) pending_pix[$].lir = 1'b1;
    end
    if (pos_col + 1 < wid) begin
      pos_col++;
    end else begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= eff_h() + rad) pos_row = 0;
    end
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [4:0] ix, input logic [15:0] v,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= {3'b000, b, g, r, v, ix};
    do @(posedge clk); while (!s_axis_tready);
    filter_accept(f, ix, v, r, g, b);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] a, input logic [15:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_WIDTH:  img_w = d[10:0];
      REG_HEIGHT: img_h = d;
      REG_RADIUS: rad_reg = d[1:0];
      default: ;
    endcase
    pos_col = 0;
    pos_row = 0;
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h, input logic [15:0] r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
  endtask

  task automatic random_position();
    logic [1:0] f;
    if ($urandom_range(0, 24) == 0)
      send_item(FN_LOAD, 5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    else if ($urandom_range(0, 30) == 0)
      send_item(FN_NONE, 5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    f = ($urandom_range(0, 6) == 0) ? FN_FLUSH : FN_PIXEL;
    send_item(f, 5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // result side: random stalls, compare against oldest prediction
  always @(posedge clk) begin
    pix_out_t e;
    cycles <= cycles + 1;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= (stall_left == 1);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_pix.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected transfer: tdata=%h", m_axis_tdata);
        end else begin
          e = pending_pix.pop_front();
          if (m_axis_tdata[7:0] !== e.red || m_axis_tdata[15:8] !== e.green ||
              m_axis_tdata[23:16] !== e.blue || m_axis_tdata[33:24] !== e.col ||
              m_axis_tdata[49:34] !== e.row || m_axis_tlast !== e.lir ||
              m_axis_tuser !== e.lof) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp rgb %h %h %h col %0d row %0d last %b lof %b",
                       e.red, e.green, e.blue, e.col, e.row, e.lir, e.lof,
                       " got rgb %h %h %h col %0d row %0d last %b lof %b",
                       m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tdata[33:24], m_axis_tdata[49:34], m_axis_tlast, m_axis_tuser);
          end
        end
      end
    end
    if (cycles > CLIP_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [13];
    int        w, h, r, npos, before_q;
    plan[0]  = '{FN_LOAD,  5'd0,  16'h1000, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,  8'd0,  8'd0};
    plan[1]  = '{FN_PIXEL, 5'd3,  16'h0,    8'd255, 8'd0,   8'd128, 1'b1, 8'd255, 8'd0, 8'd128};
    plan[2]  = '{FN_NONE,  5'd31, 16'hffff, 8'd9,   8'd9,   8'd9,   1'b0, 8'd0,  8'd0,  8'd0};
    plan[3]  = '{FN_LOAD,  5'd0,  16'h8000, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,  8'd0,  8'd0};
    plan[4]  = '{FN_PIXEL, 5'd0,  16'h0,    8'd255, 8'd1,   8'd0,   1'b1, 8'h08, 8'hf8, 8'h00};
    plan[5]  = '{FN_LOAD,  5'd0,  16'h7fff, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,  8'd0,  8'd0};
    plan[6]  = '{FN_PIXEL, 5'd0,  16'h0,    8'd255, 8'd0,   8'd1,   1'b1, 8'hf7, 8'h00, 8'h07};
    plan[7]  = '{FN_LOAD,  5'd0,  16'hffff, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,  8'd0,  8'd0};
    plan[8]  = '{FN_PIXEL, 5'd0,  16'h0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd0,  8'd0,  8'd0};
    plan[9]  = '{FN_LOAD,  5'd25, 16'h1234, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,  8'd0,  8'd0};
    plan[10] = '{FN_LOAD,  5'd31, 16'h4321, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,  8'd0,  8'd0};
    plan[11] = '{FN_FLUSH, 5'd0,  16'h0,    8'd77,  8'd77,  8'd77,  1'b1, 8'd0,  8'd0,  8'd0};
    plan[12] = '{FN_PIXEL, 5'd24, 16'h0,    8'd0,   8'd255, 8'd0,   1'b0, 8'd0,  8'd0,  8'd0};

    img_w = 11'd1024;
    img_h = 16'd1;
    rad_reg = 2'd1;
    pos_col = 0;
    pos_row = 0;
    foreach (kern[i]) kern[i] = '0;
    foreach (lines[i]) lines[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity-sized 1x1 kernel on a 2x2 frame, coefficient extremes
    set_frame(16'd2, 16'd2, 16'd0);
    for (int i = 0; i < KERN_DEPTH; i++) send_item(FN_LOAD, 5'(i), 16'h0, 8'd0, 8'd0, 8'd0);
    foreach (plan[i]) begin
      before_q = pending_pix.size();
      send_item(plan[i].func, plan[i].idx, plan[i].coef, plan[i].r, plan[i].g, plan[i].b);
      if (plan[i].chk && pending_pix.size() > before_q) begin
        pending_pix[$].red = plan[i].er;
        pending_pix[$].green = plan[i].eg;
        pending_pix[$].blue = plan[i].eb;
      end
    end

    // random frames; some cut short by a new setting
    items_sent = 0;
    while (items_sent < 230) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0: begin w = 0; h = 0; r = 3; end
        1: begin w = 2047; h = $urandom_range(1, 2); r = $urandom_range(0, 3); end
        2: begin w = 1; h = 65535; r = 2; end
        default: begin
          w = $urandom_range(1, 8); h = $urandom_range(1, 4); r = $urandom_range(0, 2);
        end
      endcase
      set_frame(16'(w), 16'(h), 16'(r));
      for (int i = 0; i < KERN_DEPTH; i++)
        send_item(FN_LOAD, 5'(i), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      npos = (eff_h() + eff_r()) * eff_w() * $urandom_range(1, 2);
      if (npos > 40) npos = $urandom_range(4, 40);
      else if ($urandom_range(0, 4) == 0) npos = $urandom_range(1, npos);
      for (int i = 0; i < npos; i++) random_position();
    end

    // last part: one short row, no idling
    idle_on = 1'b0;
    set_frame(16'd24, 16'd1, 16'd0);
    for (int i = 0; i < 24; i++) random_position();

    drain();
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule

### sim.f
sv/rgbcf_pkg.sv
sv/rgbcf_ram.sv
sv/rgbcf_queue.sv
sv/rgbcf_front.sv
sv/rgbcf_back.sv
sv/rgb_2d_convolution_filter.sv
tb/tb_top.sv
